// File: src/binning_error_accumulator_core_defines.svh
// Assertion macros used by the checker of the binning accumulator.
// No dependencies; include by bare file name.
`ifndef BINNING_ERROR_ACCUMULATOR_CORE_DEFINES_SVH
`define BINNING_ERROR_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BEA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bea assertion failed");

// Next-cycle implication, disabled during reset.
`define BEA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bea assertion failed");

`endif

// File: src/bea_pkg.sv
// Package of the binning accumulator: transaction structs, op codes and widths.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bea_pkg;

  localparam int XW  = 32;
  localparam int SQW = 64;
  localparam int FQW = 63;
  localparam int AVW = 24;
  localparam int STW = 5;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_LEVEL = 2'd1;
  localparam logic [1:0] OP_LIST  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] sample;
    logic [3:0]         slot;
  } bea_cmd_t;

  typedef struct packed {
    logic signed [XW-1:0]  partial_sum;
    logic [SQW-1:0]        sum_of_squares;
    logic signed [XW-1:0]  first_block;
    logic [FQW-1:0]        first_square;
    logic [31:0]           counted_samples;
    logic signed [AVW-1:0] average_entry;
    logic [31:0]           sample_count;
    logic [STW-1:0]        levels_used;
    logic [STW-1:0]        average_level;
    logic [STW-1:0]        average_count;
    logic                  saturated;
  } bea_res_t;

  typedef struct packed {
    logic                 valid;
    logic signed [XW-1:0] x;
    logic [31:0]          n;
  } bea_tok_t;

  typedef struct packed {
    logic                 used;
    logic                 pend;
    logic                 created;
    logic                 sat;
    logic signed [XW-1:0] partial;
    logic [SQW-1:0]       squares;
    logic signed [XW-1:0] first;
    logic [FQW-1:0]       first_sq;
  } bea_cell_t;

endpackage

`default_nettype wire

// File: src/bea_level_cell.sv
// One level of the binning chain: squares, parks or carries the block sum.
// Depends on bea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bea_level_cell
  import bea_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  bea_tok_t  tok_in,
  output bea_tok_t  tok_out,
  output bea_cell_t stat
);

  logic                 used;
  logic                 pend;
  logic                 pend_new;
  logic signed [XW-1:0] partial;
  logic signed [XW-1:0] first;
  logic [SQW-1:0]       squares;
  logic [FQW-1:0]       first_sq;
  logic [FQW-1:0]       sq;
  logic [XW-1:0]        mag;
  logic [SQW-1:0]       prod;
  logic signed [XW:0]   sum;
  logic signed [XW-1:0] carry;
  logic                 ovf;
  logic [SQW:0]         acc;

  always_comb begin
    mag   = tok_in.x[XW-1] ? XW'(-tok_in.x) : XW'(tok_in.x);
    prod  = SQW'(mag) * SQW'(mag);
    sum   = (XW+1)'(tok_in.x) + (XW+1)'(partial);
    ovf   = sum[XW] != sum[XW-1];
    if (!ovf) begin
      carry = sum[XW-1:0];
    end else if (sum[XW]) begin
      carry = {1'b1, {(XW-1){1'b0}}};
    end else begin
      carry = {1'b0, {(XW-1){1'b1}}};
    end
    acc = {1'b0, squares} + {2'b00, sq};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      pend          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid && used && tok_in.n[0];
      pend          <= tok_in.valid;
      if (tok_in.valid) begin
        sq       <= prod[FQW-1:0];
        pend_new <= !used;
        if (!used) begin
          used    <= 1'b1;
          partial <= tok_in.x;
          first   <= tok_in.x;
        end else if (!tok_in.n[0]) begin
          partial <= tok_in.x;
        end else begin
          partial   <= '0;
          tok_out.x <= carry;
          tok_out.n <= {1'b0, tok_in.n[31:1]};
        end
      end
      if (pend) begin
        if (pend_new) begin
          squares  <= {1'b0, sq};
          first_sq <= sq;
        end else begin
          squares <= acc[SQW] ? {SQW{1'b1}} : acc[SQW-1:0];
        end
      end
    end
  end

  always_comb begin
    stat.used     = used;
    stat.pend     = pend;
    stat.created  = tok_in.valid && !used;
    stat.sat      = (tok_in.valid && used && tok_in.n[0] && ovf) ||
                    (pend && !pend_new && acc[SQW]);
    stat.partial  = partial;
    stat.squares  = squares;
    stat.first    = first;
    stat.first_sq = first_sq;
  end

endmodule

`default_nettype wire

// File: src/bea_avg_list.sv
// Block-average list: appends scaled block sums and halves by pairwise averaging.
// Depends on bea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bea_avg_list
  import bea_pkg::*;
#(
  parameter int LIST_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic signed [XW-1:0]          take_x,
  input  logic                          rd_en,
  input  logic [$clog2(LIST_DEPTH)-1:0] rd_addr,
  output logic [XW-1:0]                 rd_data,
  output logic [$clog2(LIST_DEPTH+1)-1:0] fill,
  output logic [STW-1:0]                shift,
  output logic                          busy
);

  localparam int AW   = $clog2(LIST_DEPTH);
  localparam int FW   = $clog2(LIST_DEPTH + 1);
  localparam int HALF = LIST_DEPTH / 2;

  logic [XW-1:0]          mem [LIST_DEPTH];
  logic [XW-1:0]          rb;
  logic [AW-1:0]          hi;
  logic                   halving;
  logic                   issuing;
  logic                   wr_pend;
  logic [AW-1:0]          wr_addr;
  logic                   defer;
  logic signed [XW-1:0]   defer_x;
  logic signed [XW-1:0]   app_x;
  logic                   app;
  logic signed [XW+7:0]   scaled;
  logic signed [XW+7:0]   shifted;
  logic [XW:0]            pair;
  logic                   full;

  // A block sum that arrives during a halving sweep is held and appended
  // with the new shift once the sweep has finished.
  always_comb begin
    app_x   = defer ? defer_x : take_x;
    scaled  = {app_x, 8'd0};
    shifted = scaled >>> shift;
    pair    = {rd_data[XW-1], rd_data} + {rb[XW-1], rb};
    full    = fill == FW'(LIST_DEPTH);
    app     = !halving && (defer || (take && !full));
    busy    = halving || defer;
  end

  always_ff @(posedge clk) begin
    if (halving && issuing) begin
      rd_data <= mem[AW'({hi, 1'b0})];
      rb      <= mem[AW'({hi, 1'b1})];
    end else if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_pend) begin
      mem[wr_addr] <= pair[XW:1];
    end else if (app) begin
      mem[AW'(fill)] <= shifted[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      shift   <= '0;
      halving <= 1'b0;
      issuing <= 1'b0;
      wr_pend <= 1'b0;
      hi      <= '0;
      defer   <= 1'b0;
    end else begin
      wr_pend <= halving && issuing;
      if (halving && issuing) begin
        wr_addr <= hi;
        if (hi == AW'(HALF - 1)) begin
          issuing <= 1'b0;
        end else begin
          hi <= hi + 1'b1;
        end
      end else if (take && !halving && full) begin
        issuing <= 1'b1;
        hi      <= '0;
      end
      if (wr_pend && !issuing) begin
        halving <= 1'b0;
        fill    <= FW'(HALF);
        if (shift != {STW{1'b1}}) begin
          shift <= shift + 1'b1;
        end
      end else if (take && !halving && full) begin
        halving <= 1'b1;
      end else if (app) begin
        fill <= fill + 1'b1;
      end
      if (take && halving) begin
        defer   <= 1'b1;
        defer_x <= take_x;
      end else if (app) begin
        defer <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/binning_error_accumulator_core.sv
// Timing: a read registers the list entry on acceptance and then registers the result; a push
// registers the sample and then passes through the level cells it visits (one level cell per cycle).
// A push that halves the list also waits for the sweep over its memory.
// Throughput: one transaction at a time; the next is accepted once the result is registered.
// Reset (rst, synchronous, active high) clears counts, flags and all level and list valid state.
`timescale 1ns / 1ps
`default_nettype none

module binning_error_accumulator_core
  import bea_pkg::*;
#(
  parameter int LEVELS      = 16,
  parameter int LIST_DEPTH  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  bea_cmd_t cmd,
  output logic     res_valid,
  input  logic     res_stall,
  output bea_res_t res
);

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW = $clog2(LEVELS + 1);
  localparam int PW = $clog2(LEVELS + 1);
  localparam int AW = $clog2(LIST_DEPTH);
  localparam int FW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t           state;
  bea_cmd_t         req;
  logic [31:0]      total_count;
  logic [CW-1:0]    level_count;
  logic             saturated;
  bea_tok_t         tok0;
  bea_tok_t         tok  [LEVELS+1];
  bea_cell_t        stat [LEVELS];
  logic             accept;
  logic             active;
  logic             created_any;
  logic             sat_any;
  logic [PW-1:0]    lo_idx;
  logic [PW-1:0]    hi_idx;
  logic             take_lo;
  logic             take_hi;
  logic             take;
  logic signed [XW-1:0] take_x;
  logic [XW-1:0]    rd_data;
  logic [FW-1:0]    fill;
  logic [STW-1:0]   shift;
  logic             list_busy;
  logic [31:0]      raw;
  logic signed [31:0] sx;
  bea_cell_t        sel;
  logic [31:0]      bs;
  logic [31:0]      rounded;
  logic             finish;
  bea_res_t         res_next;

  assign cmd_stall = state != S_IDLE;
  assign accept    = cmd_valid && !cmd_stall;
  assign tok[0]    = tok0;

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    bea_level_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1]),
      .stat    (stat[g])
    );
  end

  // A halving raises the shift, so a block sum carried one level further in the
  // same push is taken into the list as well.
  always_comb begin
    active      = list_busy;
    created_any = 1'b0;
    sat_any     = 1'b0;
    for (int i = 0; i <= LEVELS; i++) begin
      active = active | tok[i].valid;
    end
    for (int i = 0; i < LEVELS; i++) begin
      active      = active | stat[i].pend;
      created_any = created_any | stat[i].created;
      sat_any     = sat_any | stat[i].sat;
    end
    lo_idx  = PW'(shift);
    hi_idx  = PW'(shift) + PW'(1);
    take_lo = (32'(shift) <= LEVELS) && tok[lo_idx].valid;
    take_hi = list_busy && (32'(shift) < LEVELS) && (shift != {STW{1'b1}}) &&
              tok[hi_idx].valid;
    take    = take_lo || take_hi;
    take_x  = take_hi ? tok[hi_idx].x : tok[lo_idx].x;
  end

  bea_avg_list #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_list (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .take_x  (take_x),
    .rd_en   (accept),
    .rd_addr (AW'(cmd.slot)),
    .rd_data (rd_data),
    .fill    (fill),
    .shift   (shift),
    .busy    (list_busy)
  );

  always_comb begin
    raw     = 32'({16'd0, cmd.sample}) << (32 - SAMPLE_BITS);
    sx      = $signed(raw) >>> (32 - SAMPLE_BITS);
    sel     = stat[LW'(req.slot)];
    bs      = 32'd1 << req.slot;
    rounded = total_count & ~(bs - 32'd1);
    finish  = (state == S_RUN) && !active && (!res_valid || !res_stall);

    res_next = '0;
    if (req.op == OP_LEVEL && 32'(req.slot) < 32'(level_count) && 32'(req.slot) < LEVELS) begin
      res_next.partial_sum     = sel.partial;
      res_next.sum_of_squares  = sel.squares;
      res_next.first_block     = sel.first;
      res_next.first_square    = sel.first_sq;
      res_next.counted_samples = (rounded >= bs) ? rounded - bs : 32'd0;
    end
    if (req.op == OP_LIST && 32'(req.slot) < 32'(fill) && 32'(req.slot) < LIST_DEPTH) begin
      res_next.average_entry = rd_data[AVW-1:0];
    end
    res_next.sample_count  = total_count;
    res_next.levels_used   = STW'(level_count);
    res_next.average_level = shift;
    res_next.average_count = STW'(fill);
    res_next.saturated     = saturated;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      total_count <= '0;
      level_count <= '0;
      saturated   <= 1'b0;
      tok0.valid  <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      tok0.valid  <= accept && (cmd.op == OP_PUSH);
      level_count <= level_count + CW'(created_any);
      saturated   <= saturated | sat_any;
      if (finish) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req   <= cmd;
            state <= S_RUN;
            if (cmd.op == OP_PUSH) begin
              tok0.x      <= sx;
              tok0.n      <= total_count;
              total_count <= total_count + 32'd1;
            end
          end
        end
        S_RUN: begin
          if (finish) begin
            res   <= res_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/bea_checker.sv
// Port-level checker for the binning accumulator and its bind to the top level.
// Depends on bea_pkg and binning_error_accumulator_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "binning_error_accumulator_core_defines.svh"

module bea_checker
  import bea_pkg::*;
#(
  parameter int LEVELS     = 16,
  parameter int LIST_DEPTH = 16
) (
  input logic     clk,
  input logic     rst,
  input logic     cmd_valid,
  input logic     cmd_stall,
  input logic     res_valid,
  input logic     res_stall,
  input bea_res_t res
);

  `BEA_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res))
  `BEA_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall)
  `BEA_ASSERT_IMPL(a_new_result_idle, clk, rst, $rose(res_valid), !cmd_stall)
  `BEA_ASSERT_IMPL(a_counts_bounded, clk, rst, res_valid, 32'(res.average_count) <= LIST_DEPTH && 32'(res.levels_used) <= LEVELS)

endmodule

bind binning_error_accumulator_core bea_checker #(
  .LEVELS     (LEVELS),
  .LIST_DEPTH (LIST_DEPTH)
) u_bea_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire
